// ===== src/itm_pkg.sv =====
// Shared types and constants for the interval table with merge.
package itm_pkg;
	localparam int Entries = 16;
	localparam int TimeBits = 32;
	localparam int CountBits = 32;
	localparam int IdxBits = $clog2(Entries);
	localparam int UsedBits = $clog2(Entries + 1);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_POINT = 3'd1;
	localparam logic [2:0] OP_OVERLAP = 3'd2;
	localparam logic [2:0] OP_PROBE_UP = 3'd3;
	localparam logic [2:0] OP_MERGE_UP = 3'd4;
	localparam logic [2:0] OP_PROBE_DN = 3'd5;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	// command from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} itm_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic result_ok;
	} itm_sts_t;
endpackage

// ===== src/itm_datapath.sv =====
// Datapath: entry cells, parallel compare and shift, result register.
module itm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  itm_pkg::itm_cmd_t           cmd,
	output itm_pkg::itm_sts_t           sts,
	input  logic [2:0]                  operation,
	input  logic [31:0]                 key_start,
	input  logic [31:0]                 span_length,
	input  logic [31:0]                 event_count,
	output logic                        answer,
	output logic [1:0]                  status
);
	import itm_pkg::*;

	logic [TimeBits-1:0]  beg_q [Entries];
	logic [TimeBits-1:0]  spn_q [Entries];
	logic [CountBits-1:0] evt_q [Entries];
	logic [UsedBits-1:0]  used_q;
	logic [2:0]           op_q;
	logic [TimeBits-1:0]  key_q, len_q;
	logic [CountBits-1:0] cnt_q;

	logic [Entries-1:0] valid, hit, gt, contain, ovl, adj;
	logic [TimeBits:0]  endv [Entries];
	logic [TimeBits:0]  kend;
	logic               found, any_adj_up, any_adj_dn, full;
	logic [IdxBits-1:0] slot;

	// capture the input word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			key_q <= key_start[TimeBits-1:0];
			len_q <= span_length[TimeBits-1:0];
			cnt_q <= event_count;
		end
	end

	// per-cell compare
	always_comb begin
		kend = {1'b0, key_q} + {1'b0, len_q};
		found = 1'b0;
		slot = '0;
		for (int i = 0; i < Entries; i++) begin
			valid[i] = UsedBits'(i) < used_q;
			endv[i] = {1'b0, beg_q[i]} + {1'b0, spn_q[i]};
			hit[i] = valid[i] && beg_q[i] == key_q;
			gt[i] = valid[i] && beg_q[i] > key_q;
			contain[i] = valid[i] && beg_q[i] <= key_q && {1'b0, key_q} < endv[i];
			ovl[i] = valid[i] && {1'b0, key_q} < endv[i] && {1'b0, beg_q[i]} < kend;
			if (hit[i]) begin
				found = 1'b1;
				slot = IdxBits'(i);
			end
		end
		for (int i = 0; i < Entries; i++) begin
			adj[i] = (i + 1 < Entries) ? (valid[(i + 1) % Entries] &&
				endv[i] == {1'b0, beg_q[(i + 1) % Entries]}) : 1'b0;
		end
		any_adj_up = found && adj[slot];
		any_adj_dn = found && slot != '0 && endv[slot - 1'b1] == {1'b0, key_q};
		full = used_q == UsedBits'(Entries);
	end

	// update cells and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.exec) begin
			answer <= 1'b0;
			status <= ST_DONE;
			unique case (op_q)
				OP_INSERT: begin
					if (found) begin
						spn_q[slot] <= len_q;
						evt_q[slot] <= cnt_q;
					end else if (full) begin
						status <= ST_FULL;
					end else begin
						// shift greater starts up one cell
						for (int i = 0; i < Entries; i++) begin
							if (gt[i] && i + 1 < Entries) begin
								beg_q[(i + 1) % Entries] <= beg_q[i];
								spn_q[(i + 1) % Entries] <= spn_q[i];
								evt_q[(i + 1) % Entries] <= evt_q[i];
							end
						end
						// write the new entry at the first greater start, else at the end
						for (int i = 0; i < Entries; i++) begin
							if ((gt[i] || UsedBits'(i) == used_q) &&
								(i == 0 || !gt[(i + Entries - 1) % Entries]) &&
								!(i != 0 && UsedBits'(i) > used_q)) begin
								beg_q[i] <= key_q;
								spn_q[i] <= len_q;
								evt_q[i] <= cnt_q;
							end
						end
						used_q <= used_q + 1'b1;
					end
				end
				OP_POINT: answer <= |contain;
				OP_OVERLAP: answer <= |ovl;
				OP_PROBE_UP, OP_MERGE_UP: begin
					if (!found) begin
						status <= ST_ABSENT;
					end else if (any_adj_up) begin
						answer <= 1'b1;
						if (op_q == OP_MERGE_UP) begin
							logic [TimeBits:0] ssum;
							logic [CountBits:0] csum;
							ssum = {1'b0, spn_q[slot]} + {1'b0, spn_q[slot + 1'b1]};
							csum = {1'b0, evt_q[slot]} + {1'b0, evt_q[slot + 1'b1]};
							spn_q[slot] <= ssum[TimeBits] ? '1 : ssum[TimeBits-1:0];
							evt_q[slot] <= csum[CountBits] ? '1 : csum[CountBits-1:0];
							// shift later cells down one
							for (int i = 0; i + 1 < Entries; i++) begin
								if (IdxBits'(i) > slot) begin
									beg_q[i] <= beg_q[i + 1];
									spn_q[i] <= spn_q[i + 1];
									evt_q[i] <= evt_q[i + 1];
								end
							end
							used_q <= used_q - 1'b1;
						end
					end
				end
				OP_PROBE_DN: begin
					if (!found) status <= ST_ABSENT;
					else answer <= any_adj_dn;
				end
				default: ;
			endcase
		end
	end

	assign sts.result_ok = 1'b1;
endmodule

// ===== src/itm_ctrl.sv =====
// Controller: load, execute and output handshake sequencing.
module itm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  itm_pkg::itm_sts_t sts,
	output itm_pkg::itm_cmd_t cmd
);
	import itm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT = 2'd2;

	logic [1:0] state_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign cmd.load = in_valid && in_ready;
	assign cmd.exec = state_q == S_EXEC;

	// advance through load, execute, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: if (sts.result_ok) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/interval_table_with_merge.sv =====
// Sorted interval table with point/overlap queries, adjacency probes and merge.
// One word at a time: the execute cycle right after acceptance compares all 16
// cells and shifts them in parallel, and the result is offered on the next cycle.
// Input ready drops from acceptance until the result is taken, so a word passes
// through accept, execute and deliver, and an output stall holds it in deliver.
module interval_table_with_merge (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] key_start,
	input  logic [31:0] span_length,
	input  logic [31:0] event_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        answer,
	output logic [1:0]  status
);
	import itm_pkg::*;

	itm_cmd_t cmd;
	itm_sts_t sts;

	itm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	itm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(operation), .key_start(key_start),
		.span_length(span_length), .event_count(event_count),
		.answer(answer), .status(status)
	);

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_err_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> !answer) else $error("answer on error");
`endif
endmodule
